/* rtl/core/ght_pkg.sv */
// package for the generational handle table core
// holds request and status codes, field widths, fsm state type and control structs
// no dependencies
package ght_pkg;

  // fixed field widths of the request and response channels
  localparam int unsigned REQ_W = 3;
  localparam int unsigned SLOT_W = 16;
  localparam int unsigned GEN_W = 32;
  localparam int unsigned PAY_W = 64;
  localparam int unsigned STATUS_W = 2;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD     = 3'd0,
    REQ_REMOVE  = 3'd1,
    REQ_ADOPT   = 3'd2,
    REQ_RESOLVE = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_type_e;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // request accepted, latch it and launch memory reads
    logic execute;  // memory data ready, update state and load the response
  } ght_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // response register empty or being taken this cycle
  } ght_sts_t;

endpackage

/* rtl/core/ght_if.sv */
// request and response channel interfaces of the generational handle table
// valid/ready handshake with the payload fields alongside
// depends on ght_pkg
interface ght_req_if;
  logic                         valid;
  logic                         ready;
  logic [ght_pkg::REQ_W-1:0]    req_type;
  logic [ght_pkg::SLOT_W-1:0]   slot_index;
  logic [ght_pkg::GEN_W-1:0]    handle_generation;
  logic [ght_pkg::PAY_W-1:0]    payload_in;

  modport source (output valid, req_type, slot_index, handle_generation, payload_in,
                  input ready);
  modport sink (input valid, req_type, slot_index, handle_generation, payload_in,
                output ready);
endinterface

interface ght_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ght_pkg::STATUS_W-1:0] status;
  logic [ght_pkg::SLOT_W-1:0]   slot_out;
  logic [ght_pkg::GEN_W-1:0]    generation_out;
  logic [ght_pkg::PAY_W-1:0]    payload_out;

  modport source (output valid, status, slot_out, generation_out, payload_out,
                  input ready);
  modport sink (input valid, status, slot_out, generation_out, payload_out,
                output ready);
endinterface

/* rtl/core/ght_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module ght_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ght_ctrl.sv */
// controller of the generational handle table: two-state request sequencer
// depends on ght_pkg
module ght_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ght_pkg::ght_sts_t sts_i,
  output ght_pkg::ght_cmd_t cmd_o
);

  ght_pkg::state_e state_q, state_d;
  logic            accept;

  // request taken when idle and the response register will be free
  assign accept = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ght_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ght_pkg::S_IDLE: begin
        if (accept) begin
          state_d = ght_pkg::S_EXEC;
        end
      end
      ght_pkg::S_EXEC: begin
        state_d = ght_pkg::S_IDLE;
      end
      default: begin
        state_d = ght_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      ght_pkg::S_IDLE: begin
        in_ready_o    = sts_i.out_free;
        cmd_o.capture = in_valid_i && sts_i.out_free;
      end
      ght_pkg::S_EXEC: begin
        cmd_o.execute = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/ght_dp.sv */
// datapath of the generational handle table: slot and free stack memories,
// counters, handle check and response register
// depends on ght_pkg and ght_ram
module ght_dp #(
  parameter int unsigned NUM_SLOTS    = 256,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ght_pkg::ght_cmd_t             cmd_i,
  output ght_pkg::ght_sts_t             sts_o,
  // request fields
  input  logic [ght_pkg::REQ_W-1:0]     req_type_i,
  input  logic [ght_pkg::SLOT_W-1:0]    slot_index_i,
  input  logic [ght_pkg::GEN_W-1:0]     handle_generation_i,
  input  logic [ght_pkg::PAY_W-1:0]     payload_in_i,
  // response channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ght_pkg::STATUS_W-1:0]  status_o,
  output logic [ght_pkg::SLOT_W-1:0]    slot_out_o,
  output logic [ght_pkg::GEN_W-1:0]     generation_out_o,
  output logic [ght_pkg::PAY_W-1:0]     payload_out_o
);

  localparam int unsigned IDX_W = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int unsigned GEN_W = ght_pkg::GEN_W;
  // slot entry: {generation, occupied, payload}
  localparam int unsigned ENT_W = GEN_W + 1 + PAYLOAD_BITS;
  // free stack entry: {slot, generation it will carry when reused}
  localparam int unsigned STK_W = IDX_W + GEN_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_SLOTS);

  // latched request
  logic [ght_pkg::REQ_W-1:0]  req_q;
  logic [ght_pkg::SLOT_W-1:0] idx_q;
  logic [GEN_W-1:0]           gen_q;
  logic [PAYLOAD_BITS-1:0]    pay_q;

  // table counters
  logic [CNT_W-1:0] fc_q, fc_d;
  logic [CNT_W-1:0] hw_q, hw_d;
  logic [CNT_W-1:0] fc_dec;

  // memory ports
  logic             ent_we;
  logic [IDX_W-1:0] ent_waddr;
  logic [ENT_W-1:0] ent_wdata;
  logic [ENT_W-1:0] ent_rdata;
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr;
  logic [STK_W-1:0] stk_wdata;
  logic [STK_W-1:0] stk_rdata;

  // unpacked read data
  logic [GEN_W-1:0]        ent_gen;
  logic                    ent_occ;
  logic [PAYLOAD_BITS-1:0] ent_pay;
  logic [IDX_W-1:0]        stk_slot;
  logic [GEN_W-1:0]        stk_gen;
  logic [GEN_W-1:0]        gen_inc;
  logic                    handle_ok;

  // response
  logic                          out_valid_q;
  logic [ght_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [ght_pkg::SLOT_W-1:0]    slot_q, slot_d;
  logic [GEN_W-1:0]              gen_out_q, gen_out_d;
  logic [ght_pkg::PAY_W-1:0]     pay_out_q, pay_out_d;

  assign fc_dec = fc_q - CNT_W'(1);

  // slot entry memory
  ght_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (slot_index_i[IDX_W-1:0]),
    .rdata_o (ent_rdata)
  );

  // free stack memory, read at the current top
  ght_ram #(
    .WIDTH (STK_W),
    .DEPTH (NUM_SLOTS)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (fc_dec[IDX_W-1:0]),
    .rdata_o (stk_rdata)
  );

  assign ent_gen  = ent_rdata[ENT_W-1 -: GEN_W];
  assign ent_occ  = ent_rdata[PAYLOAD_BITS];
  assign ent_pay  = ent_rdata[PAYLOAD_BITS-1:0];
  assign stk_slot = stk_rdata[STK_W-1 -: IDX_W];
  assign stk_gen  = stk_rdata[GEN_W-1:0];
  assign gen_inc  = ent_gen + GEN_W'(1);

  // handle check: below the high-water mark, occupied, matching generation
  assign handle_ok = (32'(idx_q) < 32'(hw_q)) && ent_occ && (ent_gen == gen_q);

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      idx_q <= slot_index_i;
      gen_q <= handle_generation_i;
      pay_q <= payload_in_i[PAYLOAD_BITS-1:0];
    end
  end

  // request execution
  always_comb begin
    fc_d      = fc_q;
    hw_d      = hw_q;
    ent_we    = 1'b0;
    ent_waddr = idx_q[IDX_W-1:0];
    ent_wdata = {gen_inc, 1'b0, PAYLOAD_BITS'(0)};
    stk_we    = 1'b0;
    stk_waddr = fc_q[IDX_W-1:0];
    stk_wdata = {idx_q[IDX_W-1:0], gen_inc};
    status_d  = ght_pkg::ST_OK;
    slot_d    = idx_q;
    gen_out_d = '0;
    pay_out_d = '0;
    case (req_q)
      ght_pkg::REQ_ADD: begin
        if (fc_q != '0) begin
          // reuse the most recently freed slot
          fc_d      = fc_dec;
          ent_we    = 1'b1;
          ent_waddr = stk_slot;
          ent_wdata = {stk_gen, 1'b1, pay_q};
          slot_d    = ght_pkg::SLOT_W'(stk_slot);
          gen_out_d = stk_gen;
        end else if (hw_q != CNT_FULL) begin
          // open a fresh slot at the high-water mark
          hw_d      = hw_q + CNT_W'(1);
          ent_we    = 1'b1;
          ent_waddr = hw_q[IDX_W-1:0];
          ent_wdata = {GEN_W'(1), 1'b1, pay_q};
          slot_d    = ght_pkg::SLOT_W'(hw_q[IDX_W-1:0]);
          gen_out_d = GEN_W'(1);
        end else begin
          status_d = ght_pkg::ST_FULL;
          slot_d   = '0;
        end
      end
      ght_pkg::REQ_REMOVE, ght_pkg::REQ_ADOPT, ght_pkg::REQ_RESOLVE: begin
        if (!handle_ok) begin
          status_d = ght_pkg::ST_INVALID;
        end else begin
          if (req_q != ght_pkg::REQ_REMOVE) begin
            pay_out_d = ght_pkg::PAY_W'(ent_pay);
          end
          if (req_q != ght_pkg::REQ_RESOLVE) begin
            // release: empty the slot, bump generation, push on free stack
            ent_we = 1'b1;
            if (fc_q != CNT_FULL) begin
              stk_we = 1'b1;
              fc_d   = fc_q + CNT_W'(1);
            end
          end
        end
      end
      ght_pkg::REQ_CLEAR: begin
        fc_d = '0;
        hw_d = '0;
      end
      default: begin
        status_d = ght_pkg::ST_INVALID;
      end
    endcase
    if (!cmd_i.execute) begin
      fc_d   = fc_q;
      hw_d   = hw_q;
      ent_we = 1'b0;
      stk_we = 1'b0;
    end
  end

  // counters and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q        <= '0;
      hw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fc_q <= fc_d;
      hw_q <= hw_d;
      if (cmd_i.execute) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      status_q  <= status_d;
      slot_q    <= slot_d;
      gen_out_q <= gen_out_d;
      pay_out_q <= pay_out_d;
    end
  end

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign slot_out_o       = slot_q;
  assign generation_out_o = gen_out_q;
  assign payload_out_o    = pay_out_q;

endmodule

/* rtl/core/generational_handle_table_core.sv */
// top level of the generational handle table core
// joins the request sequencer and the datapath to the channel interfaces
// depends on ght_pkg, ght_if, ght_ctrl, ght_dp
//
//   channel | dir | handshake    | fields
//   --------+-----+--------------+-----------------------------------------------
//   req_i   | in  | valid/ready  | req_type, slot_index, handle_generation, payload_in
//   rsp_o   | out | valid/ready  | status, slot_out, generation_out, payload_out
//
// for every request the slot entry and the free stack top are read from
// synchronous ram in the accept cycle, then written back and the response
// registered in the next cycle. the entry ram read-then-write sets this split.
// reset clears the free count, high-water mark and response valid at once; the
// memories need no clearing pass. a new request is taken only once the response
// register is empty or being taken, so a stalled response holds the input off.
module generational_handle_table_core #(
  parameter int unsigned NUM_SLOTS    = 256,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ght_req_if.sink   req_i,
  ght_rsp_if.source rsp_o
);

  ght_pkg::ght_cmd_t cmd;
  ght_pkg::ght_sts_t sts;
  logic              in_ready;

  assign req_i.ready = in_ready;

  // request sequencer
  ght_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table state and response
  ght_dp #(
    .NUM_SLOTS    (NUM_SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .req_type_i          (req_i.req_type),
    .slot_index_i        (req_i.slot_index),
    .handle_generation_i (req_i.handle_generation),
    .payload_in_i        (req_i.payload_in),
    .out_valid_o         (rsp_o.valid),
    .out_ready_i         (rsp_o.ready),
    .status_o            (rsp_o.status),
    .slot_out_o          (rsp_o.slot_out),
    .generation_out_o    (rsp_o.generation_out),
    .payload_out_o       (rsp_o.payload_out)
  );

endmodule
